/* rtl/core/pcef_pkg.sv */
// Shared payload types and command and register codes for the correlation edge finder.
package pcef_pkg;

  localparam logic CMD_LOAD = 1'b0;
  localparam logic CMD_ROW  = 1'b1;

  localparam logic [1:0] REG_CORR_THRESHOLD = 2'd0;
  localparam logic [1:0] REG_SAMPLE_COUNT   = 2'd1;
  localparam logic [1:0] REG_CHANNEL_COUNT  = 2'd2;

  typedef struct packed {
    logic               cmd;
    logic [5:0]         channel;
    logic [7:0]         time_index;
    logic signed [15:0] sample;
  } item_t;

  typedef struct packed {
    logic [5:0] row_channel;
    logic [5:0] col_channel;
    logic       is_edge;
    logic       last;
  } result_t;

  typedef struct packed {
    logic [1:0]  index;
    logic [15:0] value;
  } cfg_t;

endpackage

/* rtl/core/pcef_chan_if.sv */
// Valid/ready channel interface carrying one payload per transfer.
interface pcef_chan_if #(
  parameter type payload_t = logic
) ();
  logic     valid;
  logic     ready;
  payload_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

/* rtl/core/pcef_serial_mul.sv */
// Shift-and-add multiplier that retires one multiplier bit per cycle.
module pcef_serial_mul
  import pcef_pkg::*;
#(
  parameter int PW = 126,
  parameter int BW = 47
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          start,
  input  logic [PW-1:0] a,
  input  logic [BW-1:0] b,
  output logic          busy,
  output logic [PW-1:0] product
);

  logic [PW-1:0] a_sh;
  logic [BW-1:0] b_sh;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
    end else if (start) begin
      busy    <= 1'b1;
      product <= '0;
      a_sh    <= a;
      b_sh    <= b;
    end else if (busy) begin
      if (b_sh == '0) begin
        busy <= 1'b0;
      end else begin
        if (b_sh[0]) begin
          product <= product + a_sh;
        end
        a_sh <= {a_sh[PW-2:0], 1'b0};
        b_sh <= {1'b0, b_sh[BW-1:1]};
      end
    end
  end

endmodule

/* rtl/core/pearson_correlation_edge_finder.sv */
// Top level of the thresholded Pearson correlation edge finder.
//
// The item channel carries loads and row commands. A load writes one sample into
// the sample store and completes in the cycle of its transfer, so loads stream at
// one per cycle. A row command for channel i produces one result per later channel
// j in use, each telling whether the correlation of series i and j exceeds the
// threshold; the final result has last set. A row with zero variance, or with no
// later channel, produces a single non-edge result with last set.
// A row first walks series i over the n samples in use. Each later channel then
// takes a paired walk over the two read ports of the store and, unless its
// variance is zero, the shift-and-add multipliers that square the numerator and
// form the threshold-scaled variance product. One item is worked at a time; the
// item channel is ready only when idle. Results leave through an output register,
// so a stalled receiver holds the result and the row waits until it is taken. The
// configuration channel is always ready. Reset restores the default registers and
// empties the output; the sample store is not cleared, and every entry must be
// loaded before a row reads it.
module pearson_correlation_edge_finder
  import pcef_pkg::*;
#(
  parameter int MAX_CHANNELS = 64,
  parameter int MAX_SAMPLES = 256
) (
  input logic         clk,
  input logic         rst,
  pcef_chan_if.sink   item,
  pcef_chan_if.sink   cfg,
  pcef_chan_if.source result
);

  localparam int TW = $clog2(MAX_SAMPLES);
  localparam int CW = $clog2(MAX_CHANNELS);
  localparam int NW = TW + 1;
  localparam int SW = 16 + TW;
  localparam int SQW = 31 + TW;
  localparam int SXW = 32 + TW;
  localparam int VW = 31 + 2 * TW;
  localparam int MW = VW + 1;
  localparam int PW = 2 * MW + 30;
  localparam int CC_CAP = (MAX_CHANNELS < 64) ? MAX_CHANNELS : 64;

  typedef enum logic [3:0] {
    S_IDLE, S_ACC, S_PROD, S_DIFF, S_MULA, S_WAITA, S_MULB, S_WAITB, S_EMIT
  } state_t;

  state_t state;

  logic signed [15:0] cfg_threshold;
  logic [8:0]         cfg_sample_count;
  logic [6:0]         cfg_channel_count;

  logic [15:0] store [2**(CW+TW)];
  logic [15:0] rdx;
  logic [15:0] rdy;
  logic        load_we;

  logic [NW-1:0] n;
  logic [6:0]    cc;
  logic [5:0]    row;
  logic [5:0]    j;
  logic          row_pass;
  logic [NW-1:0] t_cnt;
  logic          rd_v;

  logic signed [SW-1:0]  sx;
  logic signed [SW-1:0]  sy;
  logic [SQW-1:0]        syy;
  logic signed [SXW-1:0] sxy;
  logic signed [31:0]    xy;
  logic signed [31:0]    yy;

  logic [NW+SQW-1:0]         n_syy;
  logic signed [2*SW-1:0]    sy_sq;
  logic signed [2*SW-1:0]    sx_sy;
  logic signed [NW+SXW:0]    n_sxy;
  logic [VW-1:0]             p1;
  logic [VW-1:0]             p2;
  logic signed [VW:0]        p3;
  logic signed [VW:0]        p4;
  logic [VW-1:0]             vy_w;
  logic signed [MW:0]        num_w;
  logic [MW:0]               num_abs;
  logic [VW-1:0]             vx;
  logic [VW-1:0]             vy_r;
  logic [MW-1:0]             mag_r;
  logic                      num_neg;
  logic                      num_zero;

  logic [15:0]   tmag;
  logic [31:0]   t2;
  logic          num_start;
  logic          den_start;
  logic          num_busy;
  logic          den_busy;
  logic [PW-1:0] num_prod;
  logic [PW-1:0] den_prod;
  logic [PW-1:0] den_a;
  logic [VW-1:0] den_b;
  logic [PW-1:0] lhs;

  logic [5:0] res_col;
  logic       res_last;
  logic       edge_r;

  assign cfg.ready  = 1'b1;
  assign item.ready = (state == S_IDLE);

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg_threshold     <= 16'sd16384;
      cfg_sample_count  <= 9'd256;
      cfg_channel_count <= 7'd64;
    end else if (cfg.valid) begin
      case (cfg.data.index)
        REG_CORR_THRESHOLD: cfg_threshold     <= cfg.data.value;
        REG_SAMPLE_COUNT:   cfg_sample_count  <= cfg.data.value[8:0];
        REG_CHANNEL_COUNT:  cfg_channel_count <= cfg.data.value[6:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    if ({23'd0, cfg_sample_count} > 32'(MAX_SAMPLES)) begin
      n = NW'(MAX_SAMPLES);
    end else begin
      n = NW'(cfg_sample_count);
    end
    if (cfg_channel_count > 7'(CC_CAP)) begin
      cc = 7'(CC_CAP);
    end else begin
      cc = cfg_channel_count;
    end
  end

  assign load_we = item.valid && item.ready && (item.data.cmd == CMD_LOAD)
                   && (int'(item.data.channel) < MAX_CHANNELS)
                   && (int'(item.data.time_index) < MAX_SAMPLES);

  always_ff @(posedge clk) begin
    if (load_we) begin
      store[{CW'(item.data.channel), TW'(item.data.time_index)}] <= item.data.sample;
    end
    rdx <= store[{CW'(row), TW'(t_cnt)}];
    rdy <= store[{CW'(j), TW'(t_cnt)}];
  end

  assign xy    = $signed(rdx) * $signed(rdy);
  assign yy    = $signed(rdy) * $signed(rdy);
  assign n_syy = n * syy;
  assign sy_sq = sy * sy;
  assign sx_sy = sx * sy;
  assign n_sxy = $signed({1'b0, n}) * sxy;

  assign vy_w    = p1 - p2;
  assign num_w   = {p3[VW], p3} - {p4[VW], p4};
  assign num_abs = num_w[MW] ? (~num_w + 1'b1) : num_w;

  assign tmag = cfg_threshold[15] ? (~cfg_threshold + 1'b1) : cfg_threshold;
  assign t2   = tmag * tmag;

  assign num_start = (state == S_MULA);
  assign den_start = (state == S_MULA) || (state == S_MULB);
  assign den_a     = (state == S_MULB) ? den_prod : {{(PW-VW){1'b0}}, vx};
  assign den_b     = (state == S_MULB) ? {{(VW-32){1'b0}}, t2} : vy_r;
  assign lhs       = {num_prod[PW-31:0], 30'd0};

  pcef_serial_mul #(
    .PW(PW),
    .BW(MW)
  ) u_num_mul (
    .clk     (clk),
    .rst     (rst),
    .start   (num_start),
    .a       ({{(PW-MW){1'b0}}, mag_r}),
    .b       (mag_r),
    .busy    (num_busy),
    .product (num_prod)
  );

  pcef_serial_mul #(
    .PW(PW),
    .BW(VW)
  ) u_den_mul (
    .clk     (clk),
    .rst     (rst),
    .start   (den_start),
    .a       (den_a),
    .b       (den_b),
    .busy    (den_busy),
    .product (den_prod)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      rd_v         <= 1'b0;
      result.valid <= 1'b0;
    end else begin
      if (result.valid && result.ready && state != S_EMIT) begin
        result.valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (item.valid && item.data.cmd == CMD_ROW) begin
            row <= item.data.channel;
            j   <= item.data.channel;
            if ({1'b0, item.data.channel} + 7'd1 >= cc) begin
              res_col  <= 6'd0;
              res_last <= 1'b1;
              edge_r   <= 1'b0;
              state    <= S_EMIT;
            end else begin
              row_pass <= 1'b1;
              t_cnt    <= '0;
              rd_v     <= 1'b0;
              sy       <= '0;
              syy      <= '0;
              sxy      <= '0;
              state    <= S_ACC;
            end
          end
        end
        S_ACC: begin
          if (t_cnt < n) begin
            t_cnt <= t_cnt + 1'b1;
            rd_v  <= 1'b1;
          end else begin
            rd_v <= 1'b0;
          end
          if (rd_v) begin
            sy  <= sy + {{TW{rdy[15]}}, rdy};
            syy <= syy + {{TW{1'b0}}, yy[30:0]};
            sxy <= sxy + {{TW{xy[31]}}, xy};
          end
          if (t_cnt == n && !rd_v) begin
            state <= S_PROD;
          end
        end
        S_PROD: begin
          p1    <= n_syy[VW-1:0];
          p2    <= sy_sq[VW-1:0];
          p3    <= n_sxy[VW:0];
          p4    <= sx_sy[VW:0];
          state <= S_DIFF;
        end
        S_DIFF: begin
          if (row_pass) begin
            sx <= sy;
            vx <= vy_w;
            if (vy_w == '0) begin
              res_col  <= 6'd0;
              res_last <= 1'b1;
              edge_r   <= 1'b0;
              state    <= S_EMIT;
            end else begin
              row_pass <= 1'b0;
              j        <= row + 6'd1;
              t_cnt    <= '0;
              sy       <= '0;
              syy      <= '0;
              sxy      <= '0;
              state    <= S_ACC;
            end
          end else begin
            vy_r     <= vy_w;
            mag_r    <= num_abs[MW-1:0];
            num_neg  <= num_w[MW];
            num_zero <= (num_w == '0);
            res_col  <= j;
            res_last <= ({1'b0, j} + 7'd1 == cc);
            if (vy_w == '0) begin
              edge_r <= 1'b0;
              state  <= S_EMIT;
            end else begin
              state <= S_MULA;
            end
          end
        end
        S_MULA: begin
          state <= S_WAITA;
        end
        S_WAITA: begin
          if (!num_busy && !den_busy) begin
            state <= S_MULB;
          end
        end
        S_MULB: begin
          state <= S_WAITB;
        end
        S_WAITB: begin
          if (!den_busy) begin
            if (cfg_threshold[15]) begin
              edge_r <= !num_neg || (lhs < den_prod);
            end else begin
              edge_r <= !num_neg && !num_zero && (lhs > den_prod);
            end
            state <= S_EMIT;
          end
        end
        S_EMIT: begin
          if (!result.valid || result.ready) begin
            result.valid            <= 1'b1;
            result.data.row_channel <= row;
            result.data.col_channel <= res_col;
            result.data.is_edge     <= edge_r;
            result.data.last        <= res_last;
            if (res_last) begin
              state <= S_IDLE;
            end else begin
              j     <= j + 6'd1;
              t_cnt <= '0;
              sy    <= '0;
              syy   <= '0;
              sxy   <= '0;
              state <= S_ACC;
            end
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule
